@@ sv/ffpa_pkg.sv @@
package ffpa_pkg;

  localparam int NUM_PAGES  = 64;
  localparam int PAGE_BYTES = 2048;
  localparam int RUN_LIMIT  = 'h100;

  localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
  localparam int PAGE_W     = $clog2(NUM_PAGES);
  localparam int CNT_W      = $clog2(NUM_PAGES + 1);

  localparam int SIZE_W     = 18;
  localparam int FPAGE_W    = 6;
  localparam int COUNT_W    = 7;
  localparam int PG_FULL_W  = SIZE_W + 1;
  localparam int FCMP_W     = 10;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // which values go to the result registers
  typedef enum logic [1:0] {
    RES_EMPTY,
    RES_ALLOC,
    RES_FREE
  } res_kind_t;

  typedef struct packed {
    logic      load;
    logic      scan_init;
    logic      scan_step;
    logic      rd_free;
    logic      free_latch;
    logic      wr_step;
    logic      finish;
    logic      fail;
    res_kind_t res_kind;
  } cmd_t;

  typedef struct packed {
    logic op_free;
    logic req_zero;
    logic req_bad;
    logic fpage_ok;
    logic found;
    logic exhausted;
    logic free_len_zero;
    logic wr_last;
  } stat_t;

endpackage

@@ sv/ffpa_ctrl.sv @@
module ffpa_ctrl
  import ffpa_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  input  stat_t stat,
  output cmd_t  cmd,
  output logic  busy,
  output logic  done
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_SCAN,
    S_FILL,
    S_FREE_LEN,
    S_CLEAR
  } state_t;

  state_t state, state_next;

  always_comb begin
    cmd          = '0;
    cmd.res_kind = RES_EMPTY;
    state_next   = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat.op_free) begin
          if (stat.fpage_ok) begin
            cmd.rd_free = 1'b1;
            state_next  = S_FREE_LEN;
          end else begin
            cmd.finish = 1'b1;
          end
        end else if (stat.req_zero) begin
          cmd.finish = 1'b1;
        end else if (stat.req_bad) begin
          cmd.finish = 1'b1;
          cmd.fail   = 1'b1;
        end else begin
          cmd.scan_init = 1'b1;
          state_next    = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.found) begin
          state_next = S_FILL;
        end else if (stat.exhausted) begin
          cmd.finish = 1'b1;
          cmd.fail   = 1'b1;
        end
      end
      S_FILL: begin
        cmd.wr_step = 1'b1;
        if (stat.wr_last) begin
          cmd.finish   = 1'b1;
          cmd.res_kind = RES_ALLOC;
        end
      end
      S_FREE_LEN: begin
        cmd.free_latch = 1'b1;
        if (stat.free_len_zero) begin
          cmd.finish = 1'b1;
        end else begin
          state_next = S_CLEAR;
        end
      end
      S_CLEAR: begin
        cmd.wr_step = 1'b1;
        if (stat.wr_last) begin
          cmd.finish   = 1'b1;
          cmd.res_kind = RES_FREE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    if (cmd.finish) begin
      state_next = S_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= cmd.finish;
    end
  end

  assign busy = (state != S_IDLE);

endmodule

@@ sv/ffpa_dp.sv @@
module ffpa_dp
  import ffpa_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  cmd_t               cmd,
  input  logic               op,
  input  logic [SIZE_W-1:0]  size_bytes,
  input  logic [FPAGE_W-1:0] free_page,
  output stat_t              stat,
  output logic               status,
  output logic [FPAGE_W-1:0] start_page,
  output logic [COUNT_W-1:0] page_count
);

  // page map storage, valid bits give the all-free reset state
  logic [CNT_W-1:0]     mem [NUM_PAGES];
  logic [NUM_PAGES-1:0] map_vld;
  logic [CNT_W-1:0]     rd_q;
  logic                 rd_vld;

  // request
  logic                 req_op;
  logic [CNT_W-1:0]     req_pages;
  logic                 req_zero;
  logic                 req_bad;
  logic                 fpage_ok;

  // scan
  logic [CNT_W-1:0]     rd_addr;
  logic [PAGE_W-1:0]    proc_idx;
  logic                 proc_vld;
  logic [CNT_W-1:0]     run_len;
  logic [PAGE_W-1:0]    run_start;

  // fill / clear
  logic [PAGE_W-1:0]    wr_base;
  logic [PAGE_W-1:0]    wr_cnt;
  logic [CNT_W-1:0]     clr_len;

  logic [PG_FULL_W-1:0] pages_full;
  logic                 rd_more;
  logic                 rd_en;
  logic [PAGE_W-1:0]    rd_sel;
  logic [CNT_W-1:0]     entry;
  logic [CNT_W-1:0]     run_len_inc;
  logic [PAGE_W-1:0]    hit_start;
  logic [CNT_W-1:0]     room;
  logic [CNT_W-1:0]     free_len;
  logic [CNT_W-1:0]     wr_total;
  logic [PAGE_W-1:0]    wr_addr;
  logic [CNT_W-1:0]     wr_data;

  // ceil(size / PAGE_BYTES)
  assign pages_full = ({1'b0, size_bytes} + PG_FULL_W'(PAGE_BYTES - 1)) >> PAGE_SHIFT;

  assign rd_more = (rd_addr < CNT_W'(NUM_PAGES));
  assign rd_en   = cmd.rd_free || (cmd.scan_step && rd_more);
  assign rd_sel  = cmd.rd_free ? wr_base : rd_addr[PAGE_W-1:0];
  assign entry   = rd_vld ? rd_q : '0;

  assign run_len_inc = run_len + CNT_W'(1);
  assign hit_start   = (run_len == '0) ? proc_idx : run_start;

  assign room     = CNT_W'(NUM_PAGES) - CNT_W'(wr_base);
  assign free_len = (entry > room) ? room : entry;

  assign wr_total = (req_op == OP_FREE) ? clr_len : req_pages;
  assign wr_addr  = wr_base + wr_cnt;
  assign wr_data  = (req_op == OP_FREE) ? '0 :
                    ((wr_cnt == '0) ? req_pages : CNT_W'(1));

  always_comb begin
    stat               = '0;
    stat.op_free       = (req_op == OP_FREE);
    stat.req_zero      = req_zero;
    stat.req_bad       = req_bad;
    stat.fpage_ok      = fpage_ok;
    stat.found         = proc_vld && (entry == '0) && (run_len_inc == req_pages);
    stat.exhausted     = proc_vld && (proc_idx == PAGE_W'(NUM_PAGES - 1)) && !stat.found;
    stat.free_len_zero = (free_len == '0);
    stat.wr_last       = ((CNT_W'(wr_cnt) + CNT_W'(1)) == wr_total);
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_step) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_sel];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      map_vld  <= '0;
      rd_vld   <= 1'b0;
      proc_vld <= 1'b0;
    end else begin
      if (cmd.wr_step) begin
        map_vld[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld <= map_vld[rd_sel];
      end
      if (cmd.scan_init) begin
        proc_vld <= 1'b0;
      end else if (cmd.scan_step) begin
        proc_vld <= rd_more;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_op    <= op;
      req_pages <= CNT_W'(pages_full);
      req_zero  <= (pages_full == '0);
      req_bad   <= (pages_full >= PG_FULL_W'(RUN_LIMIT)) ||
                   (pages_full > PG_FULL_W'(NUM_PAGES));
      fpage_ok  <= (FCMP_W'(free_page) < FCMP_W'(NUM_PAGES));
      wr_base   <= PAGE_W'(free_page);
    end
    if (cmd.scan_init) begin
      rd_addr   <= '0;
      run_len   <= '0;
      run_start <= '0;
    end
    if (cmd.scan_step) begin
      if (rd_more) begin
        proc_idx <= rd_addr[PAGE_W-1:0];
        rd_addr  <= rd_addr + CNT_W'(1);
      end
      if (proc_vld) begin
        if (entry == '0) begin
          if (run_len == '0) begin
            run_start <= proc_idx;
          end
          run_len <= run_len_inc;
        end else begin
          run_len <= '0;
        end
      end
      if (stat.found) begin
        wr_base <= hit_start;
        wr_cnt  <= '0;
      end
    end
    if (cmd.free_latch) begin
      clr_len <= free_len;
      wr_cnt  <= '0;
    end
    if (cmd.wr_step) begin
      wr_cnt <= wr_cnt + PAGE_W'(1);
    end
    if (cmd.finish) begin
      status <= cmd.fail;
      case (cmd.res_kind)
        RES_ALLOC: begin
          start_page <= FPAGE_W'(wr_base);
          page_count <= COUNT_W'(req_pages);
        end
        RES_FREE: begin
          start_page <= '0;
          page_count <= COUNT_W'(clr_len);
        end
        default: begin
          start_page <= '0;
          page_count <= '0;
        end
      endcase
    end
  end

endmodule

@@ sv/first_fit_page_allocator_top.sv @@
// Flow to done: a zero size or an oversized allocate ends in the check state;
//   an allocate scans to the last page of the first run that fits, then writes its pages;
//   a failed scan reads the whole map; a free reads the run length, then clears its pages, if any.
// Throughput: one item at a time, set by the one-page-per-cycle scan and write of the map.
// Reset (rst, synchronous): map reads all free at once, no clearing pass; ready next cycle.
// The result stands for one cycle under done; the receiver cannot stall it.
module first_fit_page_allocator_top
  import ffpa_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               op,
  input  logic [SIZE_W-1:0]  size_bytes,
  input  logic [FPAGE_W-1:0] free_page,
  output logic               done,
  output logic               status,
  output logic [FPAGE_W-1:0] start_page,
  output logic [COUNT_W-1:0] page_count
);

  // controller drives the datapath through cmd, watches it through stat
  cmd_t  cmd;
  stat_t stat;

  // sequencer: decode, scan, fill or clear, then one-cycle result strobe
  ffpa_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  // page map, run search counters and result registers
  ffpa_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .op         (op),
    .size_bytes (size_bytes),
    .free_page  (free_page),
    .stat       (stat),
    .status     (status),
    .start_page (start_page),
    .page_count (page_count)
  );

  // an accepted item always makes the block busy on the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted item did not raise busy");

  // result strobe is a single cycle
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("done held more than one cycle");

  // a failed request reports nothing allocated
  a_fail_empty: assert property (@(posedge clk) disable iff (rst)
    (done && status) |-> (start_page == '0 && page_count == '0))
    else $error("failed request carries a page or count");

  // the map is never scanned and written in the same cycle
  a_scan_wr_excl: assert property (@(posedge clk) disable iff (rst)
    cmd.wr_step |-> !cmd.scan_step && !cmd.rd_free)
    else $error("map read and write overlap");

endmodule

@@ sim/tb_first_fit_page_allocator_top.sv @@
`timescale 1ns / 100ps

// Bench for the first-fit page allocator.
// Items go in on start/busy. Each result shows for one cycle under done and is
// checked against a local page map kept in step with every accepted item.
module tb_first_fit_page_allocator_top;
  import ffpa_pkg::*;

  // one result as the block reports it
  typedef struct packed {
    logic               status;
    logic [FPAGE_W-1:0] start_page;
    logic [COUNT_W-1:0] page_count;
  } page_result_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic               op = OP_ALLOC;
  logic [SIZE_W-1:0]  size_bytes = '0;
  logic [FPAGE_W-1:0] free_page = '0;
  logic               done;
  logic               status;
  logic [FPAGE_W-1:0] start_page;
  logic [COUNT_W-1:0] page_count;

  // local copy of the page map: 0 free, run length at a head, 1 elsewhere in a run
  int unsigned  pg_map [NUM_PAGES];
  // heads of live runs, so well-formed frees can target them
  bit           run_head [NUM_PAGES];
  page_result_t pending_results[$];
  int           err_cnt = 0;
  // sender idling on/off; cleared for the closing stretch
  bit           idle_on = 1'b1;

  always #5 clk = ~clk;

  first_fit_page_allocator_top i_dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .op         (op),
    .size_bytes (size_bytes),
    .free_page  (free_page),
    .done       (done),
    .status     (status),
    .start_page (start_page),
    .page_count (page_count)
  );

  // Timeout: a safety stop that reports FAIL, sized for ~1400 items at the slowest item
  // plus the longest idle gap, with ample margin.
  initial begin
    #10_000_000;
    $display("tb_first_fit_page_allocator_top: FAIL");
    $finish;
  end

  // Works out the result of one request and updates the local map.
  function automatic page_result_t predict_page_request(
    input logic               req_op,
    input logic [SIZE_W-1:0]  req_size,
    input logic [FPAGE_W-1:0] req_page
  );
    int unsigned  pages;
    int unsigned  len;
    int unsigned  p;
    int unsigned  k;
    bit           fits;
    bit           found;
    page_result_t r;
    r = '0;
    if (req_op == OP_ALLOC) begin
      pages = (int'(req_size) + PAGE_BYTES - 1) / PAGE_BYTES;
      if (pages == 0) begin
        // zero size: success at page 0, map untouched
      end else if (pages >= RUN_LIMIT || pages > NUM_PAGES) begin
        r.status = 1'b1;
      end else begin
        found = 1'b0;
        // first fit: lowest start whose whole run is free and inside the map
        for (p = 0; p + pages <= NUM_PAGES && !found; p++) begin
          fits = 1'b1;
          for (k = 0; k < pages; k++)
            if (pg_map[p + k] != 0) fits = 1'b0;
          if (fits) begin
            found = 1'b1;
            for (k = 0; k < pages; k++) begin
              pg_map[p + k]   = (k == 0) ? pages : 1;
              run_head[p + k] = (k == 0);
            end
            r.start_page = p[FPAGE_W-1:0];
            r.page_count = pages[COUNT_W-1:0];
          end
        end
        if (!found) r.status = 1'b1;
      end
    end else if (int'(req_page) < NUM_PAGES) begin
      len = pg_map[req_page];
      // clearing never runs past the last page
      if (len > NUM_PAGES - int'(req_page)) len = NUM_PAGES - int'(req_page);
      for (k = 0; k < len; k++) begin
        pg_map[req_page + k]   = 0;
        run_head[req_page + k] = 1'b0;
      end
      r.page_count = len[COUNT_W-1:0];
    end
    return r;
  endfunction

  // Drives one item at the falling edge, holds it until accepted, and queues
  // its predicted result. start stays high afterward; stop_sending lowers it.
  task automatic send_request(
    input logic               req_op,
    input logic [SIZE_W-1:0]  req_size,
    input logic [FPAGE_W-1:0] req_page
  );
    int gap;
    @(negedge clk);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 11);
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start      <= 1'b1;
    op         <= req_op;
    size_bytes <= req_size;
    free_page  <= req_page;
    do @(posedge clk); while (busy);
    pending_results.push_back(predict_page_request(req_op, req_size, req_page));
  endtask

  task automatic stop_sending();
    @(negedge clk);
    start <= 1'b0;
  endtask

  task automatic wait_all_results();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic send_alloc(input int unsigned bytes);
    send_request(OP_ALLOC, bytes[SIZE_W-1:0], FPAGE_W'($urandom_range(0, NUM_PAGES - 1)));
  endtask

  task automatic send_free(input int unsigned page);
    send_request(OP_FREE, SIZE_W'($urandom_range(0, (1 << SIZE_W) - 1)), page[FPAGE_W-1:0]);
  endtask

  // Compare every done strobe against the oldest prediction.
  always @(posedge clk) begin
    page_result_t want;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        $error("result with no request outstanding: status %0d start_page %0d page_count %0d",
               status, start_page, page_count);
        err_cnt++;
      end else begin
        want = pending_results.pop_front();
        if (status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status);
          err_cnt++;
        end
        if (start_page !== want.start_page) begin
          $error("start_page: expected %0d, got %0d", want.start_page, start_page);
          err_cnt++;
        end
        if (page_count !== want.page_count) begin
          $error("page_count: expected %0d, got %0d", want.page_count, page_count);
          err_cnt++;
        end
      end
    end
  end

  // Directed corners from an empty map.
  task automatic test_directed();
    send_alloc(0);                        // zero size: page 0, nothing marked
    send_alloc((1 << SIZE_W) - 1);        // all ones: 128 pages, oversized
    send_alloc(NUM_PAGES * PAGE_BYTES + 1); // one page too many
    send_alloc(NUM_PAGES * PAGE_BYTES);   // whole pool
    send_alloc(1);                        // pool full, no fit
    send_free(0);                         // frees all 64
    send_alloc(1);                        // page 0
    send_alloc(PAGE_BYTES + 1);           // 2 pages at 1
    send_alloc(PAGE_BYTES);               // page 3
    send_free(2);                         // inside a run, clears one page
    send_free(2);                         // already free, clears nothing
    send_alloc(PAGE_BYTES);               // refills page 2
    send_free(NUM_PAGES - 1);             // free page, nothing cleared
    send_alloc((NUM_PAGES - 4) * PAGE_BYTES); // pages 4..63, up to the end
    send_free(NUM_PAGES - 1);             // tail of that run
    send_alloc(PAGE_BYTES);               // run at the very last page
    send_alloc(PAGE_BYTES);               // no room
    send_free(4);                         // head of the long run
    send_free(0);
    send_free(1);
    send_free(3);
    send_free(2);
    // ignored fields at their extremes
    send_request(OP_FREE, '1, '0);
    send_request(OP_ALLOC, '0, '1);
    stop_sending();
    wait_all_results();
  endtask

  // Mostly well-formed alloc/free traffic with random sizes, some noise.
  task automatic random_item();
    int unsigned used;
    int unsigned heads[$];
    int unsigned pages;
    int unsigned pick;
    used = 0;
    for (int i = 0; i < NUM_PAGES; i++) begin
      if (pg_map[i] != 0) used++;
      if (run_head[i]) heads.push_back(i);
    end
    pick = $urandom_range(0, 99);
    if (pick < 12) begin
      // noise: any op, any field values
      send_request(1'($urandom_range(0, 1)), SIZE_W'($urandom_range(0, (1 << SIZE_W) - 1)),
                   FPAGE_W'($urandom_range(0, NUM_PAGES - 1)));
    end else if (heads.size() != 0 && (pick < ((used > 44) ? 70 : 45))) begin
      send_free(heads[$urandom_range(0, heads.size() - 1)]);
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 65)      pages = $urandom_range(1, 4);
      else if (pick < 90) pages = $urandom_range(5, 16);
      else                pages = $urandom_range(17, NUM_PAGES);
      send_alloc(pages * PAGE_BYTES - $urandom_range(0, PAGE_BYTES - 1));
    end
  endtask

  // Random traffic; idling toggled every 50 items for stretches without gaps.
  task automatic test_random_churn(input int n);
    for (int i = 0; i < n; i++) begin
      if (i % 50 == 0) idle_on = ((i / 50) % 2 == 0);
      random_item();
    end
    idle_on = 1'b1;
  endtask

  // Sender holds off until every result is back, several times.
  task automatic test_drain_pause();
    for (int b = 0; b < 5; b++) begin
      repeat ($urandom_range(5, 30)) random_item();
      stop_sending();
      wait_all_results();
    end
  endtask

  // Closing stretch, back to back.
  task automatic test_back_to_back(input int n);
    idle_on = 1'b0;
    repeat (n) random_item();
    stop_sending();
  endtask

  initial begin
    for (int i = 0; i < NUM_PAGES; i++) begin
      pg_map[i]   = 0;
      run_head[i] = 1'b0;
    end
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed();
    test_random_churn(850);
    test_drain_pause();
    test_back_to_back(400);

    wait_all_results();
    repeat (2 * NUM_PAGES + 8) @(posedge clk);
    if (err_cnt == 0) begin
      $display("tb_first_fit_page_allocator_top: PASS");
    end else begin
      $display("tb_first_fit_page_allocator_top: FAIL");
    end
    $finish;
  end

endmodule

@@ first_fit_page_allocator_top.f @@
sv/ffpa_pkg.sv
sv/ffpa_ctrl.sv
sv/ffpa_dp.sv
sv/first_fit_page_allocator_top.sv
sim/tb_first_fit_page_allocator_top.sv
